FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; the including module must have clock and reset signals
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, ignored while in reset
`define HPT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hpt assertion failed");

// antecedent implies consequent in the next cycle, ignored while in reset
`define HPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hpt assertion failed");

// antecedent implies consequent in the next cycle, checked through reset too
`define HPT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("hpt assertion failed");

`endif

FILE: hdl/hpt_pkg.sv
// shared constants, op codes and pipeline word types of the point transform core
// no dependencies
package hpt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int SUM_W      = 66;
   localparam int QUO_W      = 33;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = QUO_W / DIV_STEPS;
   localparam int CMP_W      = 64 + QUO_W;
   localparam int DIV_W      = 64 + FRAC_BITS;

   localparam logic [31:0] COEFF_ONE = 32'(1) << FRAC_BITS;
   localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_DIR   = 2'd1;
   localparam logic [1:0] OP_POINT = 2'd2;

   typedef struct packed {
      logic                       valid;
      logic                       point;
      logic [3:0][SUM_W-1:0]      sum;
   } hpt_sum_type;

   typedef struct packed {
      logic                       valid;
      logic                       point;
      logic                       wz;
      logic                       dsat;
      logic [2:0]                 neg;
      logic [2:0]                 presat;
      logic [63:0]                aw;
      logic [2:0][63:0]           rem;
      logic [2:0][QUO_W-1:0]      quo;
      logic [2:0][QUO_W-1:0]      dlo;
      logic [2:0][31:0]           dres;
   } hpt_div_type;

endpackage

FILE: hdl/hpt_mac.sv
// coefficient matrix, input register, product stage and row sum stage
// depends on hpt_pkg
module hpt_mac
   import hpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_coeff_index,
   input  logic signed [31:0] req_coeff_value,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   input  logic               down_ready,
   output hpt_sum_type        sum_out
);

   logic               v1_ff;
   logic [1:0]         op1_ff;
   logic [3:0]         idx1_ff;
   logic [31:0]        val1_ff;
   logic signed [31:0] pin1_ff [3];
   logic [31:0]        coef_ff [16];
   logic               v2_ff;
   logic               point2_ff;
   logic signed [63:0] prod2_ff [4][3];
   logic [31:0]        tco2_ff [4];
   hpt_sum_type        sum3_ff;
   hpt_sum_type        sum3_in;
   logic               ready1;
   logic               ready2;
   logic               ready3;

   assign ready3    = !sum3_ff.valid || down_ready;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign req_stall = !ready1;
   assign sum_out   = sum3_ff;

   // unused op code is dropped at the door
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= req_valid && (req_op inside {OP_LOAD, OP_DIR, OP_POINT});
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         op1_ff     <= req_op;
         idx1_ff    <= req_coeff_index;
         val1_ff    <= req_coeff_value;
         pin1_ff[0] <= req_in_x;
         pin1_ff[1] <= req_in_y;
         pin1_ff[2] <= req_in_z;
      end
   end

   // loads write as they leave stage one, so later words see them in order
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            coef_ff[i] <= (i % 5 == 0) ? COEFF_ONE : 32'd0;
         end
      end else if (v1_ff && op1_ff == OP_LOAD && ready2) begin
         coef_ff[idx1_ff] <= val1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff && op1_ff != OP_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         point2_ff <= op1_ff == OP_POINT;
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod2_ff[r][c] <= $signed(coef_ff[r*4+c]) * pin1_ff[c];
            end
            tco2_ff[r] <= coef_ff[r*4+3];
         end
      end
   end

   always_comb begin
      logic [SUM_W-1:0] acc;
      logic [SUM_W-1:0] trans;
      sum3_in       = '0;
      sum3_in.valid = v2_ff;
      sum3_in.point = point2_ff;
      for (int r = 0; r < 4; r++) begin
         acc = '0;
         for (int c = 0; c < 3; c++) begin
            acc = acc + {{(SUM_W-64){prod2_ff[r][c][63]}}, prod2_ff[r][c]};
         end
         // translation column times 1.0
         trans = {{(SUM_W-32-FRAC_BITS){tco2_ff[r][31]}}, tco2_ff[r], {FRAC_BITS{1'b0}}};
         if (point2_ff) begin
            acc = acc + trans;
         end
         sum3_in.sum[r] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum3_ff.valid <= 1'b0;
      end else if (ready3) begin
         sum3_ff <= sum3_in;
      end
   end

endmodule

FILE: hdl/hpt_div_stage.sv
// one stage of the restoring divider: DIV_STEPS (three) quotient bits per lane
// depends on hpt_pkg
module hpt_div_stage
   import hpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  hpt_div_type din,
   output logic        up_ready,
   input  logic        down_ready,
   output hpt_div_type dout
);

   hpt_div_type stage_ff;
   hpt_div_type stage_in;

   assign up_ready = !stage_ff.valid || down_ready;
   assign dout     = stage_ff;

   always_comb begin
      logic [64:0] trial;
      stage_in = din;
      for (int k = 0; k < 3; k++) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            trial = {stage_in.rem[k], stage_in.dlo[k][QUO_W-1]};
            stage_in.dlo[k] = {stage_in.dlo[k][QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, din.aw}) begin
               stage_in.rem[k] = trial[63:0] - din.aw;
               stage_in.quo[k] = {stage_in.quo[k][QUO_W-2:0], 1'b1};
            end else begin
               stage_in.rem[k] = trial[63:0];
               stage_in.quo[k] = {stage_in.quo[k][QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (up_ready) begin
         stage_ff <= stage_in;
      end
   end

endmodule

FILE: hdl/hpt_finish.sv
// quotient rounding, clamping, sign and the result register
// depends on hpt_pkg
module hpt_finish
   import hpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  hpt_div_type        din,
   output logic               up_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_saturated,
   output logic               rsp_w_zero
);

   typedef struct packed {
      logic                  valid;
      logic                  point;
      logic                  wz;
      logic                  dsat;
      logic [2:0]            neg;
      logic [2:0]            presat;
      logic [2:0][QUO_W:0]   qr;
      logic [2:0][31:0]      dres;
   } hpt_round_type;

   hpt_round_type rnd_ff;
   hpt_round_type rnd_in;
   logic          out_v_ff;
   logic [31:0]   res_ff [3];
   logic [31:0]   res_in [3];
   logic          sat_ff;
   logic          sat_in;
   logic          wz_ff;
   logic          ready_out;

   assign ready_out = !out_v_ff || !rsp_stall;
   assign up_ready  = !rnd_ff.valid || ready_out;

   // round half away from zero on the magnitude
   always_comb begin
      rnd_in        = '0;
      rnd_in.valid  = din.valid;
      rnd_in.point  = din.point;
      rnd_in.wz     = din.wz;
      rnd_in.dsat   = din.dsat;
      rnd_in.neg    = din.neg;
      rnd_in.presat = din.presat;
      rnd_in.dres   = din.dres;
      for (int k = 0; k < 3; k++) begin
         rnd_in.qr[k] = {1'b0, din.quo[k]}
                      + (QUO_W+1)'({din.rem[k], 1'b0} >= {1'b0, din.aw});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff.valid <= 1'b0;
      end else if (up_ready) begin
         rnd_ff <= rnd_in;
      end
   end

   always_comb begin
      logic [QUO_W:0] lim;
      logic           clamp;
      lim    = '0;
      clamp  = 1'b0;
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         res_in[k] = rnd_ff.dres[k];
         if (rnd_ff.point) begin
            if (rnd_ff.wz) begin
               res_in[k] = '0;
            end else begin
               lim   = rnd_ff.neg[k] ? (QUO_W+1)'(NEG_LIMIT) : (QUO_W+1)'(POS_LIMIT);
               clamp = rnd_ff.presat[k] || rnd_ff.qr[k] > lim;
               if (clamp) begin
                  res_in[k] = rnd_ff.neg[k] ? NEG_LIMIT : POS_LIMIT;
               end else if (rnd_ff.neg[k]) begin
                  res_in[k] = 32'd0 - rnd_ff.qr[k][31:0];
               end else begin
                  res_in[k] = rnd_ff.qr[k][31:0];
               end
               sat_in = sat_in || clamp;
            end
         end
      end
      if (!rnd_ff.point) begin
         sat_in = rnd_ff.dsat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (ready_out) begin
         out_v_ff <= rnd_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
         wz_ff  <= rnd_ff.point && rnd_ff.wz;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_out_x     = res_ff[0];
   assign rsp_out_y     = res_ff[1];
   assign rsp_out_z     = res_ff[2];
   assign rsp_saturated = sat_ff;
   assign rsp_w_zero    = wz_ff;

endmodule

FILE: hdl/homogeneous_point_transform_core.sv
// channel   | handshake             | word
// req       | req_valid / req_stall | op, coeff_index, coeff_value, in_x, in_y, in_z
// rsp       | rsp_valid / rsp_stall | out_x, out_y, out_z, saturated, w_zero
// one word enters per cycle while req_stall is low; a result leaves through the
// three multiply/sum stages, two divider setup stages, eleven
// divider stages of three quotient bits each and two output stages.
// loads give no result and take effect in word order.
// reset is synchronous and restores the identity matrix at once.
// each stage holds while the one after it is full and stalled; bubbles close up.
module homogeneous_point_transform_core
   import hpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [3:0]         req_coeff_index,
   input  logic signed [31:0] req_coeff_value,
   input  logic signed [31:0] req_in_x,
   input  logic signed [31:0] req_in_y,
   input  logic signed [31:0] req_in_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_saturated,
   output logic               rsp_w_zero
);

   typedef struct packed {
      logic              valid;
      logic              point;
      logic              wz;
      logic              dsat;
      logic [2:0]        neg;
      logic [63:0]       aw;
      logic [2:0][63:0]  ax;
      logic [2:0][31:0]  dres;
   } hpt_prep_type;

   hpt_sum_type  sum_bus;
   hpt_prep_type prep_ff;
   hpt_prep_type prep_in;
   hpt_div_type  init_ff;
   hpt_div_type  init_in;
   hpt_div_type  div_bus [DIV_STAGES+1];
   logic         div_rdy [DIV_STAGES+1];
   logic         ready4;
   logic         ready5;

   assign ready5 = !init_ff.valid || div_rdy[0];
   assign ready4 = !prep_ff.valid || ready5;

   hpt_mac u_mac (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .req_in_x        (req_in_x),
      .req_in_y        (req_in_y),
      .req_in_z        (req_in_z),
      .down_ready      (ready4),
      .sum_out         (sum_bus)
   );

   // magnitudes for the divider, direction results rounded and clamped here
   always_comb begin
      logic [SUM_W:0]   rnd;
      logic [SUM_W-1:0] mag;
      logic             negw;
      logic             fits;
      prep_in       = '0;
      prep_in.valid = sum_bus.valid;
      prep_in.point = sum_bus.point;
      negw          = sum_bus.sum[3][SUM_W-1];
      mag           = negw ? SUM_W'(0) - sum_bus.sum[3] : sum_bus.sum[3];
      prep_in.aw    = mag[63:0];
      prep_in.wz    = sum_bus.sum[3] == '0;
      for (int k = 0; k < 3; k++) begin
         rnd  = {sum_bus.sum[k][SUM_W-1], sum_bus.sum[k]}
              + ((SUM_W+1)'(1) << (FRAC_BITS-1));
         fits = (rnd[SUM_W:FRAC_BITS+31] == '0) || (rnd[SUM_W:FRAC_BITS+31] == '1);
         prep_in.dres[k] = fits ? rnd[FRAC_BITS+31:FRAC_BITS]
                                : (rnd[SUM_W] ? NEG_LIMIT : POS_LIMIT);
         prep_in.dsat    = prep_in.dsat || !fits;
         mag             = sum_bus.sum[k][SUM_W-1] ? SUM_W'(0) - sum_bus.sum[k]
                                                   : sum_bus.sum[k];
         prep_in.ax[k]   = mag[63:0];
         prep_in.neg[k]  = sum_bus.sum[k][SUM_W-1] ^ negw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff.valid <= 1'b0;
      end else if (ready4) begin
         prep_ff <= prep_in;
      end
   end

   // quotient above 33 bits is caught up front, so the divider needs 33 steps
   always_comb begin
      logic [DIV_W-1:0] dd;
      init_in       = '0;
      init_in.valid = prep_ff.valid;
      init_in.point = prep_ff.point;
      init_in.wz    = prep_ff.wz;
      init_in.dsat  = prep_ff.dsat;
      init_in.neg   = prep_ff.neg;
      init_in.aw    = prep_ff.aw;
      init_in.dres  = prep_ff.dres;
      for (int k = 0; k < 3; k++) begin
         dd                = {prep_ff.ax[k], {FRAC_BITS{1'b0}}};
         init_in.presat[k] = CMP_W'(dd) >= {prep_ff.aw, {QUO_W{1'b0}}};
         init_in.rem[k]    = 64'(dd >> QUO_W);
         init_in.dlo[k]    = dd[QUO_W-1:0];
         init_in.quo[k]    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff.valid <= 1'b0;
      end else if (ready5) begin
         init_ff <= init_in;
      end
   end

   assign div_bus[0] = init_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      hpt_div_stage u_div (
         .clock      (clock),
         .reset      (reset),
         .din        (div_bus[g]),
         .up_ready   (div_rdy[g]),
         .down_ready (div_rdy[g+1]),
         .dout       (div_bus[g+1])
      );
   end

   hpt_finish u_finish (
      .clock         (clock),
      .reset         (reset),
      .din           (div_bus[DIV_STAGES]),
      .up_ready      (div_rdy[DIV_STAGES]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated),
      .rsp_w_zero    (rsp_w_zero)
   );

endmodule

FILE: hdl/hpt_checker.sv
// port level checks on the result channel of the point transform core
// depends on assert_macros.svh; bound to homogeneous_point_transform_core
`include "assert_macros.svh"

module hpt_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [31:0] rsp_out_z,
   input logic               rsp_saturated,
   input logic               rsp_w_zero
);

   logic [97:0] rsp_word;
   logic        rsp_origin;

   assign rsp_word   = {rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated, rsp_w_zero};
   assign rsp_origin = rsp_out_x == 0 && rsp_out_y == 0 && rsp_out_z == 0 && !rsp_saturated;

   // a stalled result stays offered
   `HPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   `HPT_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_word))

   // zero w gives the origin and no clamp flag
   `HPT_ASSERT_SAME(a_wzero_origin, rsp_valid && rsp_w_zero, rsp_origin)

   // pipeline is empty right after reset
   `HPT_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

endmodule

bind homogeneous_point_transform_core hpt_checker u_hpt_checker (.*);
